FILE: rtl/ssta_pkg.sv
package ssta_pkg;

  localparam int EXP_W    = 16;
  localparam int COEF_W   = 32;
  localparam int STATUS_W = 3;
  localparam int QDEPTH   = 2;
  localparam int QAW      = 1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [EXP_W-1:0]   exp;
    logic [COEF_W-1:0]  coef;
  } cmd_item_t;

  typedef struct packed {
    logic      push;
    cmd_item_t item;
  } q_wr_t;

  typedef struct packed {
    logic      empty;
    cmd_item_t item;
  } q_rd_t;

endpackage

FILE: rtl/sorted_sparse_term_accumulator_unit.sv
// Sorted sparse term accumulator: adds two sparse polynomials term by term.
// Input channel in_*: in_tuser carries the command (0 load a term of the
// first polynomial, 1 add a term of the second, 2 read out and clear; 3 is
// taken and discarded). in_tdata carries exponent and Q16.16 coefficient.
// Result channel out_*: out_tdata carries exponent and coefficient of a read
// term (zero otherwise), out_tlast marks the final result of a command and
// out_tuser the status (ok, duplicate, full, empty, saturated).
// A two-entry command queue sits between the decoder and the table engine.
// Load/add: one sweep over the stored terms, a decide step, a move of
// (term_count - position) entries for a new exponent, an insert step and a
// result step. Readout: one term per cycle while the receiver accepts them.
// The term table has one read port and one write port, which sets the pace.
// Reset empties the table at once; no clearing pass is needed. While the
// receiver stalls, the result register holds and the engine waits; commands
// are still taken until the queue fills.
module sorted_sparse_term_accumulator_unit
  import ssta_pkg::*;
#(
  parameter int MAX_TERMS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // term_exponent[15:0], term_coefficient[47:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_exponent[15:0], out_coefficient[47:16]
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // status[2:0]
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  ssta_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  ssta_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  ssta_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/ssta_front.sv
module ssta_front
  import ssta_pkg::*;
(
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               q_full,
  output q_wr_t              q_wr
);

  logic keep;
  op_t  op;

  always_comb begin
    keep = 1'b1;
    op   = OP_LOAD;
    case (in_tuser)
      OP_LOAD: op = OP_LOAD;
      OP_ADD:  op = OP_ADD;
      OP_READ: op = OP_READ;
      default: keep = 1'b0;
    endcase
  end

  // unknown commands are taken and dropped
  assign in_tready    = !q_full;
  assign q_wr.push    = in_tvalid && !q_full && keep;
  assign q_wr.item.op = op;
  assign q_wr.item.exp  = in_tdata[EXP_W-1:0];
  assign q_wr.item.coef = in_tdata[EXP_W+COEF_W-1:EXP_W];

endmodule

FILE: rtl/ssta_queue.sv
module ssta_queue
  import ssta_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  q_pop,
  output q_rd_t q_rd
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_item_t          slot_r [QDEPTH];
  logic [QAW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_pop;

  assign q_full     = (cnt_r == CNT_W'(QDEPTH));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.item  = slot_r[rp_r];
  assign do_pop     = q_pop && !q_rd.empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_wr.push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({q_wr.push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slot_r[wp_r] <= q_wr.item;
    end
  end

endmodule

FILE: rtl/ssta_back.sv
module ssta_back
  import ssta_pkg::*;
#(
  parameter int MAX_TERMS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  q_rd_t              q_rd,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,
  output logic               out_tlast,
  output logic [2:0]         out_tuser
);

  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SRCH   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_INS    = 7'b0010000,
    S_RESP   = 7'b0100000,
    S_RO     = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_item_t          cur_r, cur_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic               match_r, match_nxt;
  logic [COEF_W-1:0]  mcoef_r, mcoef_nxt;
  status_t            st_r, st_nxt;

  logic [EXP_W-1:0]   exp_mem  [DEPTH];
  logic [COEF_W-1:0]  coef_mem [DEPTH];
  logic [EXP_W-1:0]   rexp_r;
  logic [COEF_W-1:0]  rcoef_r;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic [EXP_W-1:0]   wexp;
  logic [COEF_W-1:0]  wcoef;

  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic               out_last_r;
  status_t            out_st_r;
  logic               out_free, out_load, out_last_d;
  logic [47:0]        out_data_d;
  status_t            out_st_d;

  logic [CW-1:0]      cnt_m1, idx_inc, pos_inc, j_m2;
  logic [COEF_W:0]    sum;
  logic               sat;
  logic [COEF_W-1:0]  sum_sat;
  logic               ro_last;

  assign cnt_m1  = count_r - 1'b1;
  assign idx_inc = idx_r + 1'b1;
  assign pos_inc = pos_r + 1'b1;
  assign j_m2    = j_r - 2'd2;
  assign ro_last = (idx_r == cnt_m1);
  assign out_free = !out_valid_r || out_tready;

  assign sum     = {mcoef_r[COEF_W-1], mcoef_r} + {cur_r.coef[COEF_W-1], cur_r.coef};
  assign sat     = sum[COEF_W] != sum[COEF_W-1];
  assign sum_sat = !sat ? sum[COEF_W-1:0] :
                   (sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}});

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    match_nxt  = match_r;
    mcoef_nxt  = mcoef_r;
    st_nxt     = st_r;
    q_pop      = 1'b0;
    raddr      = idx_r[AW-1:0];
    we         = 1'b0;
    waddr      = pos_r[AW-1:0];
    wexp       = cur_r.exp;
    wcoef      = cur_r.coef;
    out_load   = 1'b0;
    out_data_d = '0;
    out_last_d = 1'b1;
    out_st_d   = st_r;
    case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (!q_rd.empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_rd.item;
          idx_nxt   = '0;
          pos_nxt   = '0;
          match_nxt = 1'b0;
          if (q_rd.item.op == OP_READ) begin
            if (count_r == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_RO;
            end
          end else if (count_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // count of smaller exponents is the insertion point
        if (rexp_r < cur_r.exp) begin
          pos_nxt = pos_inc;
        end
        if (rexp_r == cur_r.exp) begin
          match_nxt = 1'b1;
          mcoef_nxt = rcoef_r;
        end
        if (ro_last) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_inc;
          raddr   = idx_inc[AW-1:0];
        end
      end
      S_DECIDE: begin
        raddr = cnt_m1[AW-1:0];
        if (match_r) begin
          if (cur_r.op == OP_LOAD) begin
            st_nxt = ST_DUP;
          end else begin
            we     = 1'b1;
            wcoef  = sum_sat;
            st_nxt = sat ? ST_SAT : ST_OK;
          end
          state_nxt = S_RESP;
        end else if (count_r == CW'(MAX_TERMS)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESP;
        end else if (pos_r == count_r) begin
          state_nxt = S_INS;
        end else begin
          j_nxt     = count_r;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // read j-2 while entry j-1 moves up to j
        we    = 1'b1;
        waddr = j_r[AW-1:0];
        wexp  = rexp_r;
        wcoef = rcoef_r;
        if (j_r == pos_inc) begin
          state_nxt = S_INS;
        end else begin
          j_nxt = j_r - 1'b1;
          raddr = j_m2[AW-1:0];
        end
      end
      S_INS: begin
        we        = 1'b1;
        count_nxt = count_r + 1'b1;
        st_nxt    = ST_OK;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RO: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = {rcoef_r, rexp_r};
          out_last_d = ro_last;
          out_st_d   = ST_OK;
          if (ro_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_inc;
            raddr   = idx_inc[AW-1:0];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      exp_mem[waddr]  <= wexp;
      coef_mem[waddr] <= wcoef;
    end
    rexp_r  <= exp_mem[raddr];
    rcoef_r <= coef_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    j_r     <= j_nxt;
    match_r <= match_nxt;
    mcoef_r <= mcoef_nxt;
    st_r    <= st_nxt;
    if (out_load) begin
      out_data_r <= out_data_d;
      out_last_r <= out_last_d;
      out_st_r   <= out_st_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count beyond table size");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> (j_r > pos_r) && (j_r <= count_r))
    else $error("shift outside occupied span");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow table");

  a_ro_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RO) && out_load && ro_last |=> count_r == '0)
    else $error("readout left terms behind");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten");

endmodule
